@@ rtl/u8dec_pkg.sv @@
`timescale 1ns / 1ps

package u8dec_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned PEND_W = 2;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CP_W-1:0]   cp_t;
  typedef logic [PEND_W-1:0] pend_t;

  // Lead byte patterns: mask and match
  localparam byte_t ASCII_MASK  = 8'h80;
  localparam byte_t LEAD2_MASK  = 8'hE0;
  localparam byte_t LEAD2_MATCH = 8'hC0;
  localparam byte_t LEAD2_DATA  = 8'h1F;
  localparam byte_t LEAD3_MASK  = 8'hF0;
  localparam byte_t LEAD3_MATCH = 8'hE0;
  localparam byte_t LEAD3_DATA  = 8'h0F;
  localparam byte_t LEAD4_MASK  = 8'hF8;
  localparam byte_t LEAD4_MATCH = 8'hF0;
  localparam byte_t LEAD4_DATA  = 8'h07;
  localparam byte_t CONT_DATA   = 8'h3F;

  localparam cp_t SURR_LO = 21'h00D800;
  localparam cp_t SURR_HI = 21'h00DFFF;
  localparam cp_t CP_MAX  = 21'h10FFFF;

endpackage

@@ rtl/u8dec_byte_if.sv @@
`timescale 1ns / 1ps

interface u8dec_byte_if
  import u8dec_pkg::*;
;
  logic  valid;
  logic  ready;
  byte_t byte_value;
  logic  last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

@@ rtl/u8dec_point_if.sv @@
`timescale 1ns / 1ps

interface u8dec_point_if
  import u8dec_pkg::*;
;
  logic valid;
  logic ready;
  cp_t  code_point;
  logic point_valid;
  logic string_end;

  modport source (output valid, output code_point, output point_valid, output string_end,
                  input ready);
  modport sink   (input valid, input code_point, input point_valid, input string_end,
                  output ready);
endinterface

@@ rtl/utf8_to_codepoint_decoder.sv @@
`timescale 1ns / 1ps

// UTF-8 decoder: one byte in, one result out, one transaction per cycle, with
// the result registered. Every byte gives a result; point_valid marks the byte
// that completes an accepted code point (surrogates and values above 0x10FFFF
// are rejected, overlong forms pass, following bytes are not checked for the
// 10xxxxxx pattern, and bad lead bytes are skipped). string_end echoes
// last_byte, and any sequence still open at that byte is dropped. The decode is
// a mask, shift and compare between the input state and one result register, so
// the block takes a byte every cycle unless the result register is held by a
// stalled sink.
module utf8_to_codepoint_decoder
  import u8dec_pkg::*;
(
  input logic          clk,
  input logic          rst,
  u8dec_byte_if.sink   bytes,
  u8dec_point_if.source points
);

  pend_t bytes_pending, bytes_pending_next;
  cp_t   code_accum, code_accum_next;
  logic  out_valid;
  cp_t   out_point;
  logic  out_ok;
  logic  out_end;

  logic  take;
  logic  done;
  logic  ok;
  cp_t   cp;
  byte_t b;

  assign bytes.ready = !out_valid || points.ready;
  assign take        = bytes.valid && bytes.ready;
  assign b           = bytes.byte_value;

  always_comb begin
    bytes_pending_next = bytes_pending;
    code_accum_next    = code_accum;
    done               = 1'b0;
    if (bytes_pending == '0) begin
      priority if ((b & ASCII_MASK) == '0) begin
        code_accum_next = cp_t'(b);
        done            = 1'b1;
      end else if ((b & LEAD2_MASK) == LEAD2_MATCH) begin
        code_accum_next    = cp_t'(b & LEAD2_DATA);
        bytes_pending_next = pend_t'(1);
      end else if ((b & LEAD3_MASK) == LEAD3_MATCH) begin
        code_accum_next    = cp_t'(b & LEAD3_DATA);
        bytes_pending_next = pend_t'(2);
      end else if ((b & LEAD4_MASK) == LEAD4_MATCH) begin
        code_accum_next    = cp_t'(b & LEAD4_DATA);
        bytes_pending_next = pend_t'(3);
      end else begin
        // skip a bad lead byte
        code_accum_next = code_accum;
      end
    end else begin
      code_accum_next    = {code_accum[CP_W-7:0], b[5:0]};
      bytes_pending_next = bytes_pending - pend_t'(1);
      done               = (bytes_pending == pend_t'(1));
    end

    cp = code_accum_next;
    ok = done && !(cp >= SURR_LO && cp <= SURR_HI) && (cp <= CP_MAX);

    if (done) begin
      code_accum_next = '0;
    end
    // drop any open sequence at end of string
    if (bytes.last_byte) begin
      bytes_pending_next = '0;
      code_accum_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= '0;
      code_accum    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (take) begin
        bytes_pending <= bytes_pending_next;
        code_accum    <= code_accum_next;
        out_valid     <= 1'b1;
      end else if (points.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_point <= ok ? cp : '0;
      out_ok    <= ok;
      out_end   <= bytes.last_byte;
    end
  end

  assign points.valid       = out_valid;
  assign points.code_point  = out_point;
  assign points.point_valid = out_ok;
  assign points.string_end  = out_end;

endmodule

@@ dv/utf8_to_codepoint_decoder_tb.sv @@
`timescale 1ns / 1ps

module utf8_to_codepoint_decoder_tb;
  import u8dec_pkg::*;

  localparam int unsigned ITEM_TARGET = 550;
  localparam int unsigned QUIET_TAIL  = 110;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT = 200000;

  localparam byte_t DIR_BYTES [24] = '{
    8'h00, 8'h7F,                  // ASCII extremes
    8'hC0, 8'h80,                  // overlong two-byte form
    8'hED, 8'hA0, 8'h80,           // surrogate
    8'hEF, 8'hBF, 8'hBF,           // top of the three-byte range
    8'hF4, 8'h8F, 8'hBF, 8'hBF,    // largest scalar value
    8'hF4, 8'h90, 8'h80, 8'h80,    // just above the scalar range
    8'h80, 8'hFF,                  // bad lead bytes
    8'hC3, 8'h41,                  // following byte without the 10 prefix
    8'hE2, 8'h82                   // string ends mid-sequence
  };
  localparam bit DIR_LAST [24] = '{
    1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1
  };

  typedef struct {
    cp_t  code_point;
    logic point_valid;
    logic string_end;
  } point_t;

  class point_scoreboard;
    point_t      expected_points[$];
    pend_t       pending;
    cp_t         accum;
    int unsigned fail_count;

    function new();
      pending    = '0;
      accum      = '0;
      fail_count = 0;
    endfunction

    // Predict the result of one accepted byte and queue it.
    function void note_byte(byte_t b, logic last);
      point_t r;
      logic   done;
      done          = 1'b0;
      r.code_point  = '0;
      r.point_valid = 1'b0;
      r.string_end  = last;
      if (pending == 0) begin
        if ((b & ASCII_MASK) == 0) begin
          accum = cp_t'(b);
          done  = 1'b1;
        end else if ((b & LEAD2_MASK) == LEAD2_MATCH) begin
          accum   = cp_t'(b & LEAD2_DATA);
          pending = 2'd1;
        end else if ((b & LEAD3_MASK) == LEAD3_MATCH) begin
          accum   = cp_t'(b & LEAD3_DATA);
          pending = 2'd2;
        end else if ((b & LEAD4_MASK) == LEAD4_MATCH) begin
          accum   = cp_t'(b & LEAD4_DATA);
          pending = 2'd3;
        end
      end else begin
        accum   = (accum << 6) | cp_t'(b & CONT_DATA);
        pending = pending - 1'b1;
        done    = (pending == 0);
      end
      if (done) begin
        if (!(accum >= SURR_LO && accum <= SURR_HI) && accum <= CP_MAX) begin
          r.code_point  = accum;
          r.point_valid = 1'b1;
        end
        accum = '0;
      end
      if (last) begin
        pending = '0;
        accum   = '0;
      end
      expected_points.insert(expected_points.size(), r);
    endfunction

    function void check_point(cp_t cp, logic pv, logic se);
      point_t e;
      if (expected_points.size() == 0) begin
        $error("unexpected result: code_point %h point_valid %b string_end %b", cp, pv, se);
        fail_count++;
        return;
      end
      e = expected_points.pop_front();
      if (cp !== e.code_point) begin
        $error("code_point: expected %h, got %h", e.code_point, cp);
        fail_count++;
      end
      if (pv !== e.point_valid) begin
        $error("point_valid: expected %b, got %b", e.point_valid, pv);
        fail_count++;
      end
      if (se !== e.string_end) begin
        $error("string_end: expected %b, got %b", e.string_end, se);
        fail_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  u8dec_byte_if  byte_ch ();
  u8dec_point_if point_ch ();

  utf8_to_codepoint_decoder dut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (byte_ch),
    .points (point_ch)
  );

  point_scoreboard sb = new();

  int unsigned sent_count  = 0;
  int unsigned cycle_count = 0;
  bit          src_idle_on = 1'b1;
  bit          sink_idle_on = 1'b1;
  bit          hold_req = 1'b0;
  byte_t       str_q[$];

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (byte_ch.valid && byte_ch.ready)
        sb.note_byte(byte_ch.byte_value, byte_ch.last_byte);
      if (point_ch.valid && point_ch.ready)
        sb.check_point(point_ch.code_point, point_ch.point_valid, point_ch.string_end);
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin : sink_side
    int unsigned stall_left;
    stall_left     = 0;
    point_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req   <= 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && sink_idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 18);
      end
      if (stall_left != 0) begin
        point_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        point_ch.ready <= 1'b1;
      end
    end
  end

  function automatic byte_t follow_byte();
    // mostly proper continuation bytes, now and then any byte at all
    if ($urandom_range(0, 7) == 0)
      return byte_t'($urandom);
    return 8'h80 | byte_t'($urandom_range(0, 63));
  endfunction

  function automatic void append_byte(byte_t b);
    str_q.insert(str_q.size(), b);
  endfunction

  function automatic void build_string();
    int unsigned n_chars;
    int unsigned kind;
    byte_t       lead;
    str_q.delete();
    n_chars = $urandom_range(1, 10);
    repeat (n_chars) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: begin
          append_byte(byte_t'($urandom_range(0, 127)));
        end
        3, 4: begin
          append_byte(LEAD2_MATCH | byte_t'($urandom_range(0, 31)));
          append_byte(follow_byte());
        end
        5, 6: begin
          // lean toward 0xED so surrogates come up often
          if ($urandom_range(0, 3) == 0)
            lead = 8'hED;
          else
            lead = LEAD3_MATCH | byte_t'($urandom_range(0, 15));
          append_byte(lead);
          repeat (2) append_byte(follow_byte());
        end
        7, 8: begin
          append_byte(LEAD4_MATCH | byte_t'($urandom_range(0, 7)));
          repeat (3) append_byte(follow_byte());
        end
        default: begin
          append_byte(byte_t'($urandom));
        end
      endcase
    end
    // leave a sequence open at the end now and then
    if ($urandom_range(0, 5) == 0) begin
      append_byte(LEAD4_MATCH | byte_t'($urandom_range(0, 7)));
      if ($urandom_range(0, 1) == 0)
        append_byte(follow_byte());
    end
  endfunction

  // Call at a falling edge; returns at the falling edge after the transaction.
  task automatic send_byte(byte_t b, logic last);
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    byte_ch.valid      <= 1'b1;
    byte_ch.byte_value <= b;
    byte_ch.last_byte  <= last;
    do @(posedge clk); while (!byte_ch.ready);
    sent_count++;
    @(negedge clk);
  endtask

  initial begin : stimulus
    bit hold_done;
    hold_done          = 1'b0;
    byte_ch.valid      = 1'b0;
    byte_ch.byte_value = '0;
    byte_ch.last_byte  = 1'b0;
    rst                = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < 24; i++)
      send_byte(DIR_BYTES[i], DIR_LAST[i]);

    while (sent_count < ITEM_TARGET) begin
      if (sent_count + QUIET_TAIL >= ITEM_TARGET) begin
        src_idle_on  = 1'b0;
        sink_idle_on <= 1'b0;
      end else begin
        src_idle_on  = ($urandom_range(0, 3) != 0);
        sink_idle_on <= ($urandom_range(0, 3) != 0);
      end
      build_string();
      // stall the result side while bytes keep coming
      if (!hold_done && sent_count >= 150) begin
        hold_done   = 1'b1;
        hold_req    <= 1'b1;
        src_idle_on = 1'b0;
        repeat (3) append_byte(byte_t'($urandom_range(0, 127)));
      end
      foreach (str_q[i])
        send_byte(str_q[i], i == str_q.size() - 1);
    end
    byte_ch.valid <= 1'b0;

    while (sb.expected_points.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/u8dec_pkg.sv
rtl/u8dec_byte_if.sv
rtl/u8dec_point_if.sv
rtl/utf8_to_codepoint_decoder.sv
dv/utf8_to_codepoint_decoder_tb.sv
